// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Field and register widths.
  localparam int FW_W    = 11;
  localparam int FH_W    = 16;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int SUM_W   = 12;
  localparam int N_W     = 4;
  localparam int X_W     = SUM_W + 1;
  localparam int RCP_W   = 17;
  localparam int RCP_SH  = 17;
  localparam int PROD_W  = X_W + RCP_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, selected by paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Reset values of the registers.
  localparam logic [FW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] HEIGHT_RST = 16'd480;

  // Reciprocal of 2n scaled by 2^17, rounded up. Exact for dividends below 2^13.
  function automatic logic [RCP_W-1:0] recip(input logic [N_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur of an RGB raster stream using two line buffer memories.
// Steps: a result passes through shift, sum, divide and output register after
//   its transfer, with an extra shift for the first drain of a single-row frame.
// Flow: in_stall holds input while not idle, so a new transfer is taken only
//   after the last; load-only ones end after shifting, dropped ones stay idle.
// Reset: a synchronous reset returns counters, window and registers to their
//   defaults; the line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Pixel input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [bb3_pkg::CH_W-1:0]     in_red_in,
  input  logic [bb3_pkg::CH_W-1:0]     in_green_in,
  input  logic [bb3_pkg::CH_W-1:0]     in_blue_in,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bb3_pkg::CH_W-1:0]     out_red_out,
  output logic [bb3_pkg::CH_W-1:0]     out_green_out,
  output logic [bb3_pkg::CH_W-1:0]     out_blue_out,
  output logic                         out_frame_end,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]  pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int FW_W   = bb3_pkg::FW_W;
  localparam int FH_W   = bb3_pkg::FH_W;
  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int PIX_W  = bb3_pkg::PIX_W;
  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int N_W    = bb3_pkg::N_W;
  localparam int X_W    = bb3_pkg::X_W;
  localparam int PROD_W = bb3_pkg::PROD_W;
  localparam int CW     = ((ADDR_W > FW_W) ? ADDR_W : FW_W) + 1;
  localparam int WCAP   = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam logic [FW_W-1:0] WCAP_V = FW_W'(WCAP);

  // Registers and counters.
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [ADDR_W-1:0] icol_r;
  logic [FH_W-1:0]   irow_r;
  logic [ADDR_W-1:0] ocol_r;
  logic [FH_W-1:0]   orow_r;
  logic              loaded_r;
  logic [PIX_W-1:0]  win_r [9];

  bb3_pkg::state_t   state_r, state_nxt;

  // Per-item latches.
  logic [PIX_W-1:0]  pix_r;
  logic              store_r;
  logic              extra_r;
  logic              top_ok_r;
  logic              mid_ok_r;

  // Line buffers and their registered read data.
  logic [PIX_W-1:0]  older_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  older_rd_r;
  logic [PIX_W-1:0]  newer_rd_r;

  // Arithmetic stage registers.
  logic [SUM_W-1:0]  sum_r_r, sum_g_r, sum_b_r;
  logic [N_W-1:0]    n_r;
  logic              last_r;
  logic [CH_W-1:0]   q_r_r, q_g_r, q_b_r;
  logic              qlast_r;

  // Output register.
  logic              out_valid_r;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic              out_end_r;

  // Combinational signals.
  logic [FW_W-1:0]   w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [CW-1:0]     w_ext;
  logic [CW-1:0]     icol_inc, ocol_inc;
  logic [FH_W:0]     irow_inc, orow_inc;
  logic              icol_wrap, irow_wrap, ocol_last, orow_last;
  logic [ADDR_W-1:0] drain_addr;
  logic              drain_top_ok;
  logic              first_extra;
  logic              ready;
  logic              accept;
  logic              pix_take, drain_take;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              out_load;
  logic              cfg_we;
  logic [PIX_W-1:0]  top_pix, mid_pix;
  logic [2:0]        col_ok, row_ok;
  logic [1:0]        ncols, nrows;
  logic [N_W-1:0]    n_cnt;
  logic [SUM_W-1:0]  sum_r_c, sum_g_c, sum_b_c;
  logic [X_W-1:0]    x_r, x_g, x_b;
  logic [bb3_pkg::RCP_W-1:0] rcp;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  // Effective frame size: zero counts as one, width clipped to the buffers.
  always_comb begin
    if (fw_r == '0) begin
      w_eff = FW_W'(1);
    end else if (fw_r > WCAP_V) begin
      w_eff = WCAP_V;
    end else begin
      w_eff = fw_r;
    end
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
    w_ext = CW'(w_eff);
  end

  // Position arithmetic for input and output counters.
  always_comb begin
    icol_inc     = CW'(icol_r) + CW'(1);
    ocol_inc     = CW'(ocol_r) + CW'(1);
    irow_inc     = {1'b0, irow_r} + (FH_W + 1)'(1);
    orow_inc     = {1'b0, orow_r} + (FH_W + 1)'(1);
    icol_wrap    = (icol_inc >= w_ext);
    irow_wrap    = (irow_inc >= {1'b0, h_eff});
    ocol_last    = (ocol_inc >= w_ext);
    orow_last    = (orow_inc >= {1'b0, h_eff});
    drain_addr   = ocol_last ? '0 : ocol_inc[ADDR_W-1:0];
    drain_top_ok = ocol_last || (orow_r != '0);
    first_extra  = (h_eff == FH_W'(1)) && (orow_r == '0) && (ocol_r == '0);
    ready        = (irow_r >= FH_W'(2)) || ((irow_r == FH_W'(1)) && (icol_r != '0));
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = (state_r != bb3_pkg::ST_IDLE);
    accept     = in_valid && !in_stall;
    pix_take   = accept && !in_func && !loaded_r;
    drain_take = accept && in_func && loaded_r;
    if (state_r == bb3_pkg::ST_IDLE) begin
      if (!in_func) begin
        mem_addr = icol_r;
      end else begin
        mem_addr = first_extra ? '0 : drain_addr;
      end
    end else begin
      mem_addr = drain_addr;
    end
    mem_we   = (state_r == bb3_pkg::ST_SHIFT) && store_r;
    out_load = (state_r == bb3_pkg::ST_OUT) && (!out_valid_r || !out_stall);
    cfg_we   = psel && penable && pwrite;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bb3_pkg::ST_IDLE: begin
        if (pix_take || drain_take) begin
          state_nxt = bb3_pkg::ST_SHIFT;
        end
      end
      bb3_pkg::ST_SHIFT: begin
        if (extra_r) begin
          state_nxt = bb3_pkg::ST_SHIFT;
        end else if (store_r && !ready) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end else begin
          state_nxt = bb3_pkg::ST_SUM;
        end
      end
      bb3_pkg::ST_SUM: begin
        state_nxt = bb3_pkg::ST_DIV;
      end
      bb3_pkg::ST_DIV: begin
        state_nxt = bb3_pkg::ST_OUT;
      end
      bb3_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bb3_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bb3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Line buffers: the older row takes what the newer row held at this column.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      older_mem[icol_r] <= newer_rd_r;
    end
    older_rd_r <= older_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      newer_mem[icol_r] <= pix_r;
    end
    newer_rd_r <= newer_mem[mem_addr];
  end

  // Column taps from the buffers, masked where the row lies above the frame.
  always_comb begin
    top_pix = top_ok_r ? older_rd_r : '0;
    mid_pix = mid_ok_r ? newer_rd_r : '0;
  end

  // Item latches and tap masks for the column being pushed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= 1'b0;
      extra_r <= 1'b0;
    end else if (state_r == bb3_pkg::ST_IDLE && (pix_take || drain_take)) begin
      store_r <= pix_take;
      extra_r <= drain_take && first_extra;
    end else if (state_r == bb3_pkg::ST_SHIFT) begin
      extra_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bb3_pkg::ST_IDLE) begin
      pix_r <= in_func ? '0 : {in_red_in, in_green_in, in_blue_in};
      if (!in_func) begin
        top_ok_r <= (irow_r >= FH_W'(2));
        mid_ok_r <= (irow_r != '0);
      end else if (first_extra) begin
        top_ok_r <= 1'b0;
        mid_ok_r <= 1'b1;
      end else begin
        top_ok_r <= drain_top_ok;
        mid_ok_r <= 1'b1;
      end
    end else if (state_r == bb3_pkg::ST_SHIFT) begin
      // The second column of a doubled drain push follows the normal rule.
      top_ok_r <= drain_top_ok;
      mid_ok_r <= 1'b1;
    end
  end

  // Frame state: window, counters and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= bb3_pkg::WIDTH_RST;
      fh_r     <= bb3_pkg::HEIGHT_RST;
      icol_r   <= '0;
      irow_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      loaded_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      // Shift the window by one column.
      if (state_r == bb3_pkg::ST_SHIFT) begin
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= win_r[i + 3];
        end
        win_r[6] <= top_pix;
        win_r[7] <= mid_pix;
        win_r[8] <= pix_r;
        if (store_r) begin
          if (icol_wrap) begin
            icol_r <= '0;
            if (irow_wrap) begin
              irow_r   <= '0;
              loaded_r <= 1'b1;
            end else begin
              irow_r <= irow_inc[FH_W-1:0];
            end
          end else begin
            icol_r <= icol_inc[ADDR_W-1:0];
          end
        end
      end
      // Advance the output position, or restart after the last result.
      if (out_load) begin
        if (qlast_r) begin
          icol_r   <= '0;
          irow_r   <= '0;
          ocol_r   <= '0;
          orow_r   <= '0;
          loaded_r <= 1'b0;
          for (int i = 0; i < 9; i++) begin
            win_r[i] <= '0;
          end
        end else if (ocol_last) begin
          ocol_r <= '0;
          orow_r <= orow_inc[FH_W-1:0];
        end else begin
          ocol_r <= ocol_inc[ADDR_W-1:0];
        end
      end
      // A register write restarts the frame.
      if (cfg_we) begin
        if (paddr[2] == bb3_pkg::REG_HEIGHT) begin
          fh_r <= pwdata[FH_W-1:0];
        end else begin
          fw_r <= pwdata[FW_W-1:0];
        end
        icol_r   <= '0;
        irow_r   <= '0;
        ocol_r   <= '0;
        orow_r   <= '0;
        loaded_r <= 1'b0;
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= '0;
        end
      end
    end
  end

  // In-frame masks and neighbor count around the output position.
  always_comb begin
    col_ok  = {!ocol_last, 1'b1, (ocol_r != '0)};
    row_ok  = {!orow_last, 1'b1, (orow_r != '0)};
    ncols   = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};
    nrows   = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
    n_cnt   = N_W'(ncols) * N_W'(nrows);
    sum_r_c = '0;
    sum_g_c = '0;
    sum_b_c = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[c] && row_ok[r]) begin
          sum_r_c = sum_r_c + SUM_W'(win_r[c * 3 + r][PIX_W-1 -: CH_W]);
          sum_g_c = sum_g_c + SUM_W'(win_r[c * 3 + r][2*CH_W-1 -: CH_W]);
          sum_b_c = sum_b_c + SUM_W'(win_r[c * 3 + r][CH_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bb3_pkg::ST_SUM) begin
      sum_r_r <= sum_r_c;
      sum_g_r <= sum_g_c;
      sum_b_r <= sum_b_c;
      n_r     <= n_cnt;
      last_r  <= orow_last && ocol_last;
    end
  end

  // Rounded mean (2*sum + n) / (2n) by a scaled reciprocal.
  always_comb begin
    rcp    = bb3_pkg::recip(n_r);
    x_r    = {sum_r_r, 1'b0} + X_W'(n_r);
    x_g    = {sum_g_r, 1'b0} + X_W'(n_r);
    x_b    = {sum_b_r, 1'b0} + X_W'(n_r);
    prod_r = PROD_W'(x_r) * PROD_W'(rcp);
    prod_g = PROD_W'(x_g) * PROD_W'(rcp);
    prod_b = PROD_W'(x_b) * PROD_W'(rcp);
  end

  always_ff @(posedge clk) begin
    if (state_r == bb3_pkg::ST_DIV) begin
      q_r_r   <= prod_r[bb3_pkg::RCP_SH +: CH_W];
      q_g_r   <= prod_g[bb3_pkg::RCP_SH +: CH_W];
      q_b_r   <= prod_b[bb3_pkg::RCP_SH +: CH_W];
      qlast_r <= last_r;
    end
  end

  // Output register; a result waits here until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= q_r_r;
      out_green_r <= q_g_r;
      out_blue_r  <= q_b_r;
      out_end_r   <= qlast_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;
  assign out_frame_end = out_end_r;

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      bb3_pkg::REG_HEIGHT: prdata = bb3_pkg::PDATA_W'(fh_r);
      default:             prdata = bb3_pkg::PDATA_W'(fw_r);
    endcase
  end

  assign pready = 1'b1;

endmodule
